// ===== rtl/peu_pkg.sv =====
`timescale 1ns / 1ps

package peu_pkg;

   // Width of every pixel field on the ports.
   localparam int PIX_W = 32;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVISION   = 2'd1;

   // Number of pixel positions in the largest block.
   localparam int BLOCK_MAX = 9;
   localparam int POS_W     = 4;

   typedef enum logic [1:0] {
      MODE_2X2 = 2'd0,
      MODE_2X3 = 2'd1,
      MODE_2X4 = 2'd2,
      MODE_3X3 = 2'd3
   } mode_type;

   // Which stored pixel feeds an output position.
   localparam int SEL_W = 3;
   typedef enum logic [SEL_W-1:0] {
      SEL_E = 3'd0,
      SEL_B = 3'd1,
      SEL_D = 3'd2,
      SEL_F = 3'd3,
      SEL_H = 3'd4
   } sel_type;

   // Number of pixels kept per queued block: E, B, D, F and H.
   localparam int SLOTS = 5;

   typedef struct packed {
      logic [BLOCK_MAX-1:0][SEL_W-1:0] sel;
      mode_type                        mode;
   } plan_type;

endpackage

// ===== rtl/peu_req_if.sv =====
`timescale 1ns / 1ps

interface peu_req_if import peu_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] up_left;
   logic [PIX_W-1:0] up_mid;
   logic [PIX_W-1:0] up_right;
   logic [PIX_W-1:0] mid_left;
   logic [PIX_W-1:0] center_pixel;
   logic [PIX_W-1:0] mid_right;
   logic [PIX_W-1:0] down_left;
   logic [PIX_W-1:0] down_mid;
   logic [PIX_W-1:0] down_right;

   modport source (
      output valid, up_left, up_mid, up_right, mid_left, center_pixel,
             mid_right, down_left, down_mid, down_right,
      input  ready
   );
   modport sink (
      input  valid, up_left, up_mid, up_right, mid_left, center_pixel,
             mid_right, down_left, down_mid, down_right,
      output ready
   );
endinterface

// ===== rtl/peu_rsp_if.sv =====
`timescale 1ns / 1ps

interface peu_rsp_if import peu_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_pixel;
   logic [1:0]       sub_col;
   logic [1:0]       sub_row;
   logic             last_flag;

   modport source (
      output valid, out_pixel, sub_col, sub_row, last_flag,
      input  ready
   );
   modport sink (
      input  valid, out_pixel, sub_col, sub_row, last_flag,
      output ready
   );
endinterface

// ===== rtl/peu_csr_if.sv =====
`timescale 1ns / 1ps

interface peu_csr_if import peu_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== rtl/peu_front.sv =====
`timescale 1ns / 1ps

module peu_front import peu_pkg::*; #(
   parameter int PIXEL_BITS = 32
) (
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [BLOCK_MAX-1:0][PIXEL_BITS-1:0] win,
   input  mode_type                            mode,
   input  logic [2:0]                          revision,
   output logic                                push_valid,
   input  logic                                push_full,
   output logic [SLOTS-1:0][PIXEL_BITS-1:0]    push_pix,
   output plan_type                            push_plan
);

   logic [PIXEL_BITS-1:0] a, b, c, d, e, f, g, h, i;
   logic db, bf, dh, hf, da, bc, dg, hi, ea, ec, eg, ei, eb, eh;
   logic k0, k1, k2, k3, p0, p1, p2, p3, q0, q1, q2, q3, m2, m3;
   logic e1, e3, e5, e7;
   logic [BLOCK_MAX-1:0] hit;
   sel_type src;

   assign req_ready  = !push_full;
   assign push_valid = req_valid;

   assign {i, h, g, f, e, d, c, b, a} = win;
   assign push_pix = {h, f, d, b, e};

   always_comb begin
      db = (d == b);
      bf = (b == f);
      dh = (d == h);
      hf = (h == f);
      da = (d == a);
      bc = (b == c);
      dg = (d == g);
      hi = (h == i);
      ea = (e == a);
      ec = (e == c);
      eg = (e == g);
      ei = (e == i);
      eb = (e == b);
      eh = (e == h);

      // Basic corner rules.
      k0 = db && !bf && !dh;
      k1 = bf && !db && !hf;
      k2 = dh && !db && !hf;
      k3 = hf && !dh && !bf;
      // Corner rules that also fire when the diagonal agrees.
      p0 = db && ((!bf && !dh) || da);
      p1 = bf && ((!db && !hf) || bc);
      p2 = dh && ((!db && !hf) || dg);
      p3 = hf && ((!dh && !bf) || hi);
      // Corner rules gated only by the diagonal differing from the center.
      q0 = db && !ea;
      q1 = bf && !ec;
      q2 = dh && !eg;
      q3 = hf && !ei;
      // Middle rows of the tall blocks.
      m2 = (k0 && !eg) || (k2 && !ea);
      m3 = (k1 && !ei) || (k3 && !ec);

      // Edge pixels of the 3x3 block.
      case (revision)
         3'd5: begin
            e1 = (k0 && !ec) || (k1 && !eb);
            e3 = (k0 && !ec) || (k2 && !eh);
            e5 = (k1 && !eb) || (k3 && !eh);
            e7 = (k2 && !eh) || (k3 && !eh);
         end
         3'd6: begin
            e1 = k0 != k1;
            e3 = k0 != k2;
            e5 = k1 != k3;
            e7 = k2 != k3;
         end
         3'd7: begin
            e1 = k0 || k1;
            e3 = k0 || k2;
            e5 = k1 || k3;
            e7 = k2 || k3;
         end
         default: begin
            e1 = (k0 && !ec) || (k1 && !ea);
            e3 = (k0 && !eg) || (k2 && !ea);
            e5 = (k1 && !ei) || (k3 && !ec);
            e7 = (k2 && !ei) || (k3 && !eg);
         end
      endcase

      hit = '0;
      case (mode)
         MODE_2X2: begin
            case (revision)
               3'd1:    hit[3:0] = {k3, k2, k1, k0};
               3'd2:    hit[3:0] = {p3, p2, p1, p0};
               3'd3:    hit[3:0] = {q3, q2, q1, q0};
               default: hit = '0;
            endcase
         end
         MODE_2X3: begin
            if (revision == 3'd1) begin
               hit[5:0] = {k3, k2, m3, m2, k1, k0};
            end
         end
         MODE_2X4: begin
            case (revision)
               3'd1:    hit[7:0] = {k3, k2, m3, m2, m3, m2, k1, k0};
               3'd2:    hit[7:0] = {k3, k2, k3, k2, k1, k0, k1, k0};
               default: hit = '0;
            endcase
         end
         MODE_3X3: begin
            case (revision)
               3'd0: hit = '0;
               3'd2: {hit[8], hit[6], hit[2], hit[0]} = {k3, k2, k1, k0};
               3'd3: {hit[8], hit[6], hit[2], hit[0]} = {p3, p2, p1, p0};
               3'd4: {hit[8], hit[6], hit[2], hit[0]} = {q3, q2, q1, q0};
               default: begin
                  {hit[8], hit[6], hit[2], hit[0]} = {k3, k2, k1, k0};
                  {hit[7], hit[5], hit[3], hit[1]} = {e7, e5, e3, e1};
               end
            endcase
         end
         default: hit = '0;
      endcase

      // Each position takes its fixed neighbor when its rule fires.
      push_plan.mode = mode;
      for (int n = 0; n < BLOCK_MAX; n++) begin
         if (mode == MODE_3X3) begin
            case (n)
               0, 3, 6: src = SEL_D;
               2, 5, 8: src = SEL_F;
               1:       src = SEL_B;
               7:       src = SEL_H;
               default: src = SEL_E;
            endcase
         end else begin
            src = ((n % 2) == 0) ? SEL_D : SEL_F;
         end
         push_plan.sel[n] = hit[n] ? src : SEL_E;
      end
   end

endmodule

// ===== rtl/peu_queue.sv =====
`timescale 1ns / 1ps

module peu_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/peu_back.sv =====
`timescale 1ns / 1ps

module peu_back import peu_pkg::*; #(
   parameter int PIXEL_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  logic [SLOTS-1:0][PIXEL_BITS-1:0] head_pix,
   input  plan_type                         head_plan,
   output logic                             head_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [PIXEL_BITS-1:0]            rsp_pixel,
   output logic [1:0]                       rsp_col,
   output logic [1:0]                       rsp_row,
   output logic                             rsp_last
);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [1:0]            col_ff, col_in, row_ff, row_in;
   logic                  valid_ff, valid_in;
   logic [PIXEL_BITS-1:0] pixel_ff, pixel_in;
   logic [1:0]            out_col_ff, out_row_ff;
   logic                  last_ff;
   logic [1:0]            last_col, last_row;
   logic                  at_end, advance;
   sel_type               code;

   assign rsp_valid = valid_ff;
   assign rsp_pixel = pixel_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_last  = last_ff;

   always_comb begin
      last_col = (head_plan.mode == MODE_3X3) ? 2'd2 : 2'd1;
      case (head_plan.mode)
         MODE_2X2: last_row = 2'd1;
         MODE_2X3: last_row = 2'd2;
         MODE_2X4: last_row = 2'd3;
         default:  last_row = 2'd2;
      endcase

      at_end   = (col_ff == last_col) && (row_ff == last_row);
      advance  = head_valid && (!valid_ff || rsp_ready);
      head_pop = advance && at_end;

      code = sel_type'(head_plan.sel[pos_ff]);
      case (code)
         SEL_B:   pixel_in = head_pix[1];
         SEL_D:   pixel_in = head_pix[2];
         SEL_F:   pixel_in = head_pix[3];
         SEL_H:   pixel_in = head_pix[4];
         default: pixel_in = head_pix[0];
      endcase

      pos_in   = pos_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      valid_in = valid_ff && !rsp_ready;
      if (advance) begin
         valid_in = 1'b1;
         if (at_end) begin
            pos_in = '0;
            col_in = '0;
            row_in = '0;
         end else if (col_ff == last_col) begin
            pos_in = pos_ff + 1'b1;
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff   <= pixel_in;
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
         last_ff    <= at_end;
      end
   end

endmodule

// ===== rtl/pixel_art_edge_upscaler.sv =====
// Edge-directed pixel-art enlarger: each request carries one source pixel's
// 3x3 neighborhood and produces the enlarged block for the center pixel, in
// row-major order, as 4 (2x2), 6 (2x3), 8 (2x4) or 9 (3x3) responses, each
// tagged with its sub-row and sub-column and with last_flag on the block's
// final pixel. Register 0 (scale_mode) picks the block shape and register 1
// (revision) the rule set; revision 0, or a revision past the highest one
// defined for the shape, copies the center pixel everywhere. Only the low
// PIXEL_BITS bits of each pixel take part. The response port delivers one
// pixel per cycle while the receiver holds ready high. The front end
// classifies a request in the cycle it is taken and can take a new one
// every cycle while its two-entry queue has room; when the queue and the
// response register are empty, the first pixel of a block is presented at
// the clock edge after the one that accepts its request. Configuration
// should only be written while no block is outstanding.
`timescale 1ns / 1ps

module pixel_art_edge_upscaler import peu_pkg::*; #(
   parameter int PIXEL_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   peu_req_if.sink   req_bus,
   peu_rsp_if.source rsp_bus,
   peu_csr_if.sink   csr_bus
);

   // Queue entry: the five pixels a block can draw from plus the per-position
   // selection plan.
   localparam int ENTRY_W = SLOTS * PIXEL_BITS + $bits(plan_type);
   localparam int QUEUE_DEPTH = 2;

   mode_type   mode_ff, mode_in;
   logic [2:0] revision_ff, revision_in;

   logic [BLOCK_MAX-1:0][PIXEL_BITS-1:0] win;
   logic                                 push_valid, push_full;
   logic [SLOTS-1:0][PIXEL_BITS-1:0]     push_pix, head_pix;
   plan_type                             push_plan, head_plan;
   logic [ENTRY_W-1:0]                   push_data, head_data;
   logic                                 head_valid, head_pop;
   logic [PIXEL_BITS-1:0]                rsp_pixel;

   // Configuration registers; writes to unused indexes are dropped.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      revision_in = revision_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SCALE_MODE: mode_in     = mode_type'(csr_bus.data[1:0]);
            CSR_REVISION:   revision_in = csr_bus.data[2:0];
            default: begin
               mode_in     = mode_ff;
               revision_in = revision_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_2X2;
         revision_ff <= 3'd1;
      end else begin
         mode_ff     <= mode_in;
         revision_ff <= revision_in;
      end
   end

   // The neighborhood, cut down to the pixel width, in A through I order.
   assign win = {req_bus.down_right[PIXEL_BITS-1:0],
                 req_bus.down_mid[PIXEL_BITS-1:0],
                 req_bus.down_left[PIXEL_BITS-1:0],
                 req_bus.mid_right[PIXEL_BITS-1:0],
                 req_bus.center_pixel[PIXEL_BITS-1:0],
                 req_bus.mid_left[PIXEL_BITS-1:0],
                 req_bus.up_right[PIXEL_BITS-1:0],
                 req_bus.up_mid[PIXEL_BITS-1:0],
                 req_bus.up_left[PIXEL_BITS-1:0]};

   // The front end runs all equality tests and resolves, for every output
   // position, which pixel it will show.
   peu_front #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .win        (win),
      .mode       (mode_ff),
      .revision   (revision_ff),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_pix   (push_pix),
      .push_plan  (push_plan)
   );

   assign push_data = {push_pix, push_plan};

   peu_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (push_full),
      .pop        (head_pop),
      .pop_data   (head_data),
      .not_empty  (head_valid)
   );

   assign {head_pix, head_plan} = head_data;

   // The back end walks the block one pixel per cycle, when not stalled,
   // into the response register; the last pixel releases the queue entry.
   peu_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pix   (head_pix),
      .head_plan  (head_plan),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_pixel  (rsp_pixel),
      .rsp_col    (rsp_bus.sub_col),
      .rsp_row    (rsp_bus.sub_row),
      .rsp_last   (rsp_bus.last_flag)
   );

   assign rsp_bus.out_pixel = PIX_W'(rsp_pixel);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

import peu_pkg::*;

typedef struct {
   logic [PIX_W-1:0] ul, um, ur, ml, ctr, mr, dl, dm, dr;
} window_type;

typedef struct {
   logic [PIX_W-1:0] pixel;
   logic [1:0]       col;
   logic [1:0]       row;
   logic             last;
} block_pixel_type;

class block_checker_type;
   mode_type         mode;
   logic [2:0]       rev;
   logic [PIX_W-1:0] pix_mask;
   block_pixel_type  pending_pixels[$];
   int               errors;
   int               windows_seen;
   int               pixels_checked;

   function new(int pixel_bits);
      mode = MODE_2X2;
      rev = 3'd1;
      pix_mask = {PIX_W{1'b1}} >> (PIX_W - pixel_bits);
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      if (index == CSR_SCALE_MODE) begin
         mode = mode_type'(data[1:0]);
      end else if (index == CSR_REVISION) begin
         rev = data[2:0];
      end
   endfunction

   function int pending();
      return pending_pixels.size();
   endfunction

   task report(string what);
      errors++;
      if (errors <= 30) begin
         $display("[%0t] error: %s", $time, what);
      end
   endtask

   // Works out the enlarged block for one neighborhood and queues its pixels.
   function void take_window(window_type w);
      logic [PIX_W-1:0] ul, um, ur, ml, ctr, mr, dl, dm, dr;
      logic [PIX_W-1:0] blk[9];
      logic [PIX_W-1:0] lean[4], guard[4], anti[4];
      logic [PIX_W-1:0] side_l, side_r;
      bit               k0, k1, k2, k3;
      bit               c0, c1, c2, c3;
      bit               e1, e3, e5, e7;
      int               cols, rows, n;
      block_pixel_type  bp;

      ul = w.ul & pix_mask;   um = w.um & pix_mask;   ur = w.ur & pix_mask;
      ml = w.ml & pix_mask;   ctr = w.ctr & pix_mask; mr = w.mr & pix_mask;
      dl = w.dl & pix_mask;   dm = w.dm & pix_mask;   dr = w.dr & pix_mask;
      windows_seen++;

      k0 = ml == um && um != mr && ml != dm;
      k1 = um == mr && um != ml && mr != dm;
      k2 = ml == dm && ml != um && dm != mr;
      k3 = dm == mr && ml != dm && um != mr;

      // Three flavors of corner rule, shared by the 2x2 and 3x3 shapes.
      lean[0] = k0 ? ml : ctr;
      lean[1] = k1 ? mr : ctr;
      lean[2] = k2 ? ml : ctr;
      lean[3] = k3 ? mr : ctr;
      guard[0] = (ml == um && ((um != mr && ml != dm) || ml == ul)) ? ml : ctr;
      guard[1] = (um == mr && ((um != ml && mr != dm) || um == ur)) ? mr : ctr;
      guard[2] = (ml == dm && ((ml != um && dm != mr) || ml == dl)) ? ml : ctr;
      guard[3] = (dm == mr && ((ml != dm && um != mr) || dm == dr)) ? mr : ctr;
      anti[0] = (ml == um && ul != ctr) ? ml : ctr;
      anti[1] = (um == mr && ur != ctr) ? mr : ctr;
      anti[2] = (ml == dm && dl != ctr) ? ml : ctr;
      anti[3] = (dm == mr && dr != ctr) ? mr : ctr;
      side_l = ((k0 && ctr != dl) || (k2 && ctr != ul)) ? ml : ctr;
      side_r = ((k1 && ctr != dr) || (k3 && ctr != ur)) ? mr : ctr;

      for (n = 0; n < 9; n++) begin
         blk[n] = ctr;
      end
      cols = 2;
      rows = 2;
      case (mode)
         MODE_2X2: begin
            for (n = 0; n < 4; n++) begin
               if (rev == 1) begin
                  blk[n] = lean[n];
               end else if (rev == 2) begin
                  blk[n] = guard[n];
               end else if (rev == 3) begin
                  blk[n] = anti[n];
               end
            end
         end
         MODE_2X3: begin
            rows = 3;
            if (rev == 1) begin
               blk[0] = lean[0];
               blk[1] = lean[1];
               blk[2] = side_l;
               blk[3] = side_r;
               blk[4] = lean[2];
               blk[5] = lean[3];
            end
         end
         MODE_2X4: begin
            rows = 4;
            if (rev == 1) begin
               blk[0] = lean[0];
               blk[1] = lean[1];
               blk[2] = side_l;
               blk[3] = side_r;
               blk[4] = side_l;
               blk[5] = side_r;
               blk[6] = lean[2];
               blk[7] = lean[3];
            end else if (rev == 2) begin
               blk[0] = lean[0];
               blk[1] = lean[1];
               blk[2] = lean[0];
               blk[3] = lean[1];
               blk[4] = lean[2];
               blk[5] = lean[3];
               blk[6] = lean[2];
               blk[7] = lean[3];
            end
         end
         default: begin
            cols = 3;
            rows = 3;
            if (rev >= 2 && rev <= 4) begin
               for (n = 0; n < 4; n++) begin
                  blk[(n / 2) * 6 + (n % 2) * 2] =
                     (rev == 2) ? lean[n] : (rev == 3) ? guard[n] : anti[n];
               end
            end else if (rev != 0) begin
               blk[0] = lean[0];
               blk[2] = lean[1];
               blk[6] = lean[2];
               blk[8] = lean[3];
               c0 = k0 && ctr != ur;
               c1 = k1 && ctr != um;
               c2 = k2 && ctr != dm;
               c3 = k3 && ctr != dm;
               if (rev == 1) begin
                  e1 = (k0 && ctr != ur) || (k1 && ctr != ul);
                  e3 = (k0 && ctr != dl) || (k2 && ctr != ul);
                  e5 = (k1 && ctr != dr) || (k3 && ctr != ur);
                  e7 = (k2 && ctr != dr) || (k3 && ctr != dl);
               end else if (rev == 5) begin
                  e1 = c0 || c1;
                  e3 = c0 || c2;
                  e5 = c1 || c3;
                  e7 = c2 || c3;
               end else if (rev == 6) begin
                  e1 = k0 != k1;
                  e3 = k0 != k2;
                  e5 = k1 != k3;
                  e7 = k2 != k3;
               end else begin
                  e1 = k0 || k1;
                  e3 = k0 || k2;
                  e5 = k1 || k3;
                  e7 = k2 || k3;
               end
               blk[1] = e1 ? um : ctr;
               blk[3] = e3 ? ml : ctr;
               blk[5] = e5 ? mr : ctr;
               blk[7] = e7 ? dm : ctr;
            end
         end
      endcase

      for (n = 0; n < cols * rows; n++) begin
         bp.pixel = blk[n] & pix_mask;
         bp.col = 2'(n % cols);
         bp.row = 2'(n / cols);
         bp.last = (n + 1 == cols * rows);
         pending_pixels.push_back(bp);
      end
   endfunction

   task check_pixel(logic [PIX_W-1:0] pixel, logic [1:0] col, logic [1:0] row,
                    logic last);
      block_pixel_type want;
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
         report($sformatf("stray pixel %h row %0d col %0d last %0b",
                          pixel, row, col, last));
      end else begin
         want = pending_pixels.pop_front();
         if (pixel !== want.pixel || col !== want.col || row !== want.row ||
             last !== want.last) begin
            report($sformatf("got %h r%0d c%0d last %0b, wanted %h r%0d c%0d last %0b",
                             pixel, row, col, last,
                             want.pixel, want.row, want.col, want.last));
         end
      end
   endtask
endclass

module testbench;

   localparam int PIXEL_BITS = 32;
   // Register indexes that the block must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   // Length of the one long response stall, in cycles.
   localparam int LONG_HOLD = 60;
   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Phase in which the response side holds off for the one long stall.
   localparam int HOLD_PHASE = 3;
   // Phases from this one on run without any idling.
   localparam int CALM_PHASE = 28;

   logic clock = 1'b0;
   logic reset;

   peu_req_if req_if ();
   peu_rsp_if rsp_if ();
   peu_csr_if csr_if ();

   pixel_art_edge_upscaler #(.PIXEL_BITS(PIXEL_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   block_checker_type board = new(PIXEL_BITS);

   // Handshake with the response side: set by the main process, read by the
   // ready generator below.
   logic calm;
   logic long_hold_req;
   int   stall_left = 0;
   bit   long_hold_taken = 1'b0;
   int   idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response ready. Normally it drops out for random bursts. Once, on
   // request, it stays low for the LONG_HOLD stall so that the block's queue
   // fills and the request side is pushed back. In the calm tail of the run
   // it stays high.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (long_hold_req && !long_hold_taken) begin
         long_hold_taken = 1'b1;
         stall_left = LONG_HOLD - 1;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: every accepted request is predicted, every accepted response
   // is checked against the oldest predicted pixel, and every register
   // write updates the predictor's copy of the registers. The same block
   // keeps the watchdog, which counts cycles with no handshake at all.
   always @(posedge clock) begin
      window_type w;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            board.write_reg(csr_if.index, csr_if.data);
         end
         if (req_if.valid && req_if.ready) begin
            w.ul = req_if.up_left;   w.um = req_if.up_mid;       w.ur = req_if.up_right;
            w.ml = req_if.mid_left;  w.ctr = req_if.center_pixel; w.mr = req_if.mid_right;
            w.dl = req_if.down_left; w.dm = req_if.down_mid;     w.dr = req_if.down_right;
            board.take_window(w);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_pixel(rsp_if.out_pixel, rsp_if.sub_col, rsp_if.sub_row,
                              rsp_if.last_flag);
         end
         if ((csr_if.valid && csr_if.ready) || (req_if.valid && req_if.ready) ||
             (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic window_type window_of(logic [PIX_W-1:0] ul, um, ur, ml, ctr, mr,
                                            dl, dm, dr);
      window_type w;
      w.ul = ul; w.um = um;   w.ur = ur;
      w.ml = ml; w.ctr = ctr; w.mr = mr;
      w.dl = dl; w.dm = dm;   w.dr = dr;
      return w;
   endfunction

   // Random neighborhood. The nine pixels are drawn from a palette of two to
   // four colors, so the equality tests that steer the rules come out both
   // ways often. Sometimes two colors differ in a single bit only.
   function automatic window_type rand_window();
      logic [PIX_W-1:0] pal[4];
      int               span;
      int               pick;
      pal[0] = $urandom;
      pal[1] = $urandom;
      pal[2] = $urandom;
      pal[3] = $urandom;
      pick = $urandom_range(0, 9);
      span = (pick < 5) ? 2 : (pick < 8) ? 3 : 4;
      if ($urandom_range(0, 3) == 0) begin
         pal[1] = pal[0] ^ (32'd1 << $urandom_range(0, PIX_W - 1));
      end
      return window_of(pal[$urandom_range(0, span - 1)], pal[$urandom_range(0, span - 1)],
                       pal[$urandom_range(0, span - 1)], pal[$urandom_range(0, span - 1)],
                       pal[$urandom_range(0, span - 1)], pal[$urandom_range(0, span - 1)],
                       pal[$urandom_range(0, span - 1)], pal[$urandom_range(0, span - 1)],
                       pal[$urandom_range(0, span - 1)]);
   endfunction

   // Offers one request and returns at the edge where it is taken. Valid is
   // left high, so back-to-back requests need no extra edge.
   task send_window(window_type w);
      req_if.valid        <= 1'b1;
      req_if.up_left      <= w.ul;
      req_if.up_mid       <= w.um;
      req_if.up_right     <= w.ur;
      req_if.mid_left     <= w.ml;
      req_if.center_pixel <= w.ctr;
      req_if.mid_right    <= w.mr;
      req_if.down_left    <= w.dl;
      req_if.down_mid     <= w.dm;
      req_if.down_right   <= w.dr;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Random gap on the request side.
   task request_gap();
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted pixel has come out. The
   // first edge lets the monitor log the last accepted request.
   task wait_all_blocks();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // Sets shape and rule set with random junk in the unused data bits, and
   // slips in a write to one of the spare indexes, which must change nothing.
   task program_block(mode_type mode, logic [2:0] rev);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      csr_write(CSR_SCALE_MODE, {junk[CSR_DATA_W-1:2], mode});
      csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      junk = $urandom;
      csr_write(CSR_REVISION, {junk[CSR_DATA_W-1:3], rev});
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      window_type directed[9];
      logic [4:0] order[32];
      logic [4:0] swap;
      int         j, p, count;
      logic [PIX_W-1:0] x, y;

      // Every input gets a known value before the first edge.
      reset               <= 1'b1;
      calm                <= 1'b0;
      long_hold_req       <= 1'b0;
      req_if.valid        <= 1'b0;
      req_if.up_left      <= '0;
      req_if.up_mid       <= '0;
      req_if.up_right     <= '0;
      req_if.mid_left     <= '0;
      req_if.center_pixel <= '0;
      req_if.mid_right    <= '0;
      req_if.down_left    <= '0;
      req_if.down_mid     <= '0;
      req_if.down_right   <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= '0;
      csr_if.data         <= '0;

      // Directed neighborhoods: all-zero and all-one pixels, the top-left and
      // top-right diagonal edge patterns, all edge neighbors equal (no rule fires),
      // corners matching the edges, alternating extremes, and neighbors that
      // differ from the center in just the top or the bottom bit.
      x = 32'h5A3C_96E1;
      y = 32'hA5C3_691E;
      directed[0] = window_of('0, '0, '0, '0, '0, '0, '0, '0, '0);
      directed[1] = window_of('1, '1, '1, '1, '1, '1, '1, '1, '1);
      directed[2] = window_of(y, x, y, x, y, y, y, y, y);
      directed[3] = window_of(y, x, y, y, y, x, y, y, y);
      directed[4] = window_of(y, x, y, x, y, x, y, x, y);
      directed[5] = window_of(x, x, '0, x, y, '1, '0, '1, '1);
      directed[6] = window_of('0, '1, '0, '1, '0, '1, '0, '1, '0);
      directed[7] = window_of(x, x, x, x, x ^ 32'h8000_0000, x, x, x, x);
      directed[8] = window_of(x, x ^ 32'd1, x, x, x, x ^ 32'd1, x, x ^ 32'd1, x);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The first directed pass runs on the reset register values, the
      // second on the 3x3 shape.
      for (j = 0; j < 9; j++) begin
         if ($urandom_range(0, 3) == 0) begin
            request_gap();
         end
         send_window(directed[j]);
      end
      wait_all_blocks();
      program_block(MODE_3X3, 3'd1);
      for (j = 0; j < 9; j++) begin
         send_window(directed[j]);
      end

      // Random part: every shape with every rule set number, in shuffled
      // order, each as a phase of its own. Registers only change once all
      // outstanding pixels have come out.
      for (j = 0; j < 32; j++) begin
         order[j] = 5'(j);
      end
      for (j = 31; j > 0; j--) begin
         p = $urandom_range(0, j);
         swap = order[j];
         order[j] = order[p];
         order[p] = swap;
      end

      for (p = 0; p < 32; p++) begin
         wait_all_blocks();
         if (p == CALM_PHASE) begin
            calm <= 1'b1;
         end
         program_block(mode_type'(order[p][1:0]), order[p][4:2]);
         // In the hold phase the response side stalls for a long stretch
         // while requests keep coming without gaps, so the block backs up.
         if (p == HOLD_PHASE) begin
            long_hold_req <= 1'b1;
         end
         count = $urandom_range(8, 14);
         repeat (count) begin
            if (p != HOLD_PHASE && p < CALM_PHASE && $urandom_range(0, 3) == 0) begin
               request_gap();
            end
            send_window(rand_window());
         end
      end

      wait_all_blocks();
      // Give the block time to show any pixel it should not produce.
      repeat (20) @(posedge clock);

      $display("Ran %0d neighborhoods through all four block shapes and all eight",
               board.windows_seen);
      $display("rule set numbers, with spare-index writes, and checked %0d pixels.",
               board.pixels_checked);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
